// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/rwr_pkg.sv
// Types and constants for the row word realigner.
// No dependencies; imported by every module of the block.
`default_nettype none

package rwr_pkg;

   localparam int WORD_W  = 32;
   localparam int SHIFT_W = 5;
   localparam int AMT_W   = SHIFT_W + 1;  // holds WORD_W itself

   // Configuration register indexes
   localparam logic [1:0] CSR_LEFT_SHIFT = 2'd0;
   localparam logic [1:0] CSR_RIGHT_EDGE = 2'd1;
   localparam logic [1:0] CSR_NEW_FORMAT = 2'd2;

   typedef struct packed {
      logic [SHIFT_W-1:0] left_shift;
      logic [SHIFT_W-1:0] right_edge_bit;
      logic               new_format;
   } cfg_type;

   // Work item classes handed from front to back
   typedef enum logic [2:0] {
      OP_PASS      = 3'd0,  // word as is, last = row end
      OP_JOIN      = 3'd1,  // joined word, not last
      OP_JOIN_LAST = 3'd2,  // joined word, last (trailing word dropped)
      OP_JOIN_TAIL = 3'd3,  // joined word, then leftover word as last
      OP_TAIL      = 3'd4   // single-word row: leftover word as last
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [WORD_W-1:0] prev_word;
      logic [WORD_W-1:0] cur_word;
      logic              row_end;
   } entry_type;

   typedef struct packed {
      logic tail_pending;
   } back_status_type;

endpackage

`default_nettype wire

// File: rtl/rwr_front.sv
// Front end: accepts source words, tracks the held word and classifies each item.
// Depends on rwr_pkg.
`default_nettype none

module rwr_front
   import rwr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [WORD_W-1:0] req_word_in,
   input  wire logic              req_row_end,
   input  wire logic              q_full,
   output logic                   q_push,
   output entry_type              q_entry
);

   logic [WORD_W-1:0] held_ff, held_in;
   logic              holding_ff, holding_in;
   logic              accept, pass, drop, has_op;
   op_type            op;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Classify the incoming word
   always_comb begin
      pass   = (cfg.left_shift == '0) || cfg.new_format;
      drop   = cfg.right_edge_bit < cfg.left_shift;
      has_op = 1'b1;
      op     = OP_PASS;
      if (pass) begin
         op = OP_PASS;
      end else if (holding_ff) begin
         if (!req_row_end) begin
            op = OP_JOIN;
         end else if (drop) begin
            op = OP_JOIN_LAST;
         end else begin
            op = OP_JOIN_TAIL;
         end
      end else if (req_row_end && !drop) begin
         op = OP_TAIL;
      end else begin
         has_op = 1'b0;  // first word of a row, or single-word row dropped
      end
   end

   assign q_push            = accept && has_op;
   assign q_entry.op        = op;
   assign q_entry.prev_word = held_ff;
   assign q_entry.cur_word  = req_word_in;
   assign q_entry.row_end   = req_row_end;

   // Held word state
   always_comb begin
      held_in    = held_ff;
      holding_in = holding_ff;
      if (accept) begin
         held_in    = req_word_in;
         holding_in = !pass && !req_row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         holding_ff <= 1'b0;
      end else begin
         held_ff    <= held_in;
         holding_ff <= holding_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/rwr_queue.sv
// Short FIFO of classified work items between front and back.
// Depends on rwr_pkg.
`default_nettype none

module rwr_queue
   import rwr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      head,
   output logic           empty,
   output logic           full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign count = count_ff;
   assign head  = store_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/rwr_back.sv
// Back end: funnel-shifts queued items and drives the registered result channel.
// Depends on rwr_pkg.
`default_nettype none

module rwr_back
   import rwr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire entry_type         head,
   input  wire logic              q_empty,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [WORD_W-1:0]      rsp_word_out,
   output logic                   rsp_row_last,
   output back_status_type        status
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              last_ff, last_in;
   logic              pending_ff, pending_in;
   logic [WORD_W-1:0] tail_ff, tail_in;
   logic              out_free;
   logic [AMT_W-1:0]  up_amt;
   logic [WORD_W-1:0] joined, tail_word;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = out_free && !pending_ff && !q_empty;

   // Funnel shift of held and current words
   always_comb begin
      up_amt    = AMT_W'(WORD_W) - AMT_W'(cfg.left_shift);
      joined    = (head.prev_word >> cfg.left_shift) | (head.cur_word << up_amt);
      tail_word = head.cur_word >> cfg.left_shift;
   end

   // Output register loading
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      pending_in   = pending_ff;
      tail_in      = tail_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (pending_ff) begin
            rsp_valid_in = 1'b1;
            word_in      = tail_ff;
            last_in      = 1'b1;
            pending_in   = 1'b0;
         end else if (!q_empty) begin
            rsp_valid_in = 1'b1;
            unique case (head.op)
               OP_PASS: begin
                  word_in = head.cur_word;
                  last_in = head.row_end;
               end
               OP_JOIN: begin
                  word_in = joined;
                  last_in = 1'b0;
               end
               OP_JOIN_LAST: begin
                  word_in = joined;
                  last_in = 1'b1;
               end
               OP_JOIN_TAIL: begin
                  word_in    = joined;
                  last_in    = 1'b0;
                  pending_in = 1'b1;
                  tail_in    = tail_word;
               end
               OP_TAIL: begin
                  word_in = tail_word;
                  last_in = 1'b1;
               end
               default: begin
                  word_in = head.cur_word;
                  last_in = head.row_end;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
      tail_ff <= tail_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_word_out        = word_ff;
   assign rsp_row_last        = last_ff;
   assign status.tail_pending = pending_ff;

endmodule

`default_nettype wire

// File: rtl/row_word_realigner.sv
// Row word realigner: the work item of an accepted request is written to the queue at the
// accepting edge, and a result word is valid on rsp once the back end loads its output register.
// One source word per cycle is taken while the queue is not full; a row end that also emits
// the leftover word makes the back end produce a second word, which the QUEUE_DEPTH-entry
// queue absorbs. Synchronous active-high reset clears control state and sets left_shift 0,
// right_edge_bit 31, new_format 0.
`default_nettype none
`include "assert_macros.svh"

module row_word_realigner
   import rwr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [WORD_W-1:0]     req_word_in,
   input  wire logic                  req_row_end,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [WORD_W-1:0]          rsp_word_out,
   output logic                       rsp_row_last,
   // configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [SHIFT_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cfg_type          cfg_ff, cfg_in;
   logic             q_push, q_pop, q_empty, q_full;
   entry_type        q_entry, q_head;
   logic [CNT_W-1:0] q_count;
   back_status_type  back_status;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEFT_SHIFT: cfg_in.left_shift     = csr_wdata;
            CSR_RIGHT_EDGE: cfg_in.right_edge_bit = csr_wdata;
            CSR_NEW_FORMAT: cfg_in.new_format     = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_shift     <= '0;
         cfg_ff.right_edge_bit <= '1;
         cfg_ff.new_format     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rwr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word_in (req_word_in),
      .req_row_end (req_row_end),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   rwr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full),
      .count      (q_count)
   );

   rwr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (q_head),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word_out (rsp_word_out),
      .rsp_row_last (rsp_row_last),
      .status       (back_status)
   );

   // Checks
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, q_count <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_tail_behind_out, clock, reset, back_status.tail_pending, rsp_valid)
   `ASSERT_NEXT(a_tail_is_last, clock, reset, back_status.tail_pending && rsp_ready, rsp_valid && rsp_row_last)
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, q_pop, !q_empty && !back_status.tail_pending)

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for row_word_realigner: directed rows, then random rows
// under several register settings and idle patterns. Depends on rwr_pkg and the RTL.

module tb_top;
   import rwr_pkg::*;

   localparam int          RANDOM_WORDS    = 1625;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          DRAIN_LIMIT     = 20000;
   localparam int          RX_STALL_CYCLES = 80;
   localparam int          STALL_BURST     = 40;
   localparam logic [1:0]  CSR_SPARE       = 2'd3;  // unused index, writes are ignored
   localparam int          SEND_IDLE [3]   = '{29, 81, 0};
   localparam int          RECV_IDLE [3]   = '{81, 29, 0};

   // one destination word
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } dest_word_type;

   // results typed in by hand for a directed request
   typedef struct packed {
      bit                on;
      bit [1:0]          count;
      logic [WORD_W-1:0] w0;
      bit                l0;
      logic [WORD_W-1:0] w1;
      bit                l1;
   } typed_result_type;

   // directed row: optional register setting, then one request
   typedef struct packed {
      bit                 set_cfg;
      bit [SHIFT_W-1:0]   shift;
      bit [SHIFT_W-1:0]   redge;
      bit                 fmt;
      logic [WORD_W-1:0]  word;
      bit                 row_end;
      typed_result_type   note;
   } dir_row_type;

   localparam typed_result_type NO_TYPED = '0;
   localparam int DIR_N = 24;
   localparam dir_row_type DIR_TABLE [DIR_N] = '{
      // reset values: zero shift passes words through
      '{1'b0, 5'd0,  5'd0,  1'b0, 32'hFFFFFFFF, 1'b0, '{1'b1, 2'd1, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0}},
      '{1'b0, 5'd0,  5'd0,  1'b0, 32'h00000000, 1'b1, '{1'b1, 2'd1, 32'h00000000, 1'b1, 32'h0, 1'b0}},
      '{1'b0, 5'd0,  5'd0,  1'b0, 32'hA5A5A5A5, 1'b1, NO_TYPED},
      // widest shift, trailing word kept; first word is only held
      '{1'b1, 5'd31, 5'd31, 1'b0, 32'hFFFFFFFF, 1'b0, '{1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0}},
      '{1'b0, 5'd31, 5'd31, 1'b0, 32'h00000000, 1'b1,
        '{1'b1, 2'd2, 32'h00000001, 1'b0, 32'h00000000, 1'b1}},
      '{1'b0, 5'd31, 5'd31, 1'b0, 32'h80000000, 1'b1,
        '{1'b1, 2'd1, 32'h00000001, 1'b1, 32'h0, 1'b0}},
      '{1'b0, 5'd31, 5'd31, 1'b0, 32'h12345678, 1'b0, NO_TYPED},
      '{1'b0, 5'd31, 5'd31, 1'b0, 32'h9ABCDEF0, 1'b0, NO_TYPED},
      '{1'b0, 5'd31, 5'd31, 1'b0, 32'h0F0F0F0F, 1'b1, NO_TYPED},
      // edge below shift: single-word row gives nothing, longer row drops its tail
      '{1'b1, 5'd1,  5'd0,  1'b0, 32'hFFFFFFFF, 1'b1, '{1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0}},
      '{1'b0, 5'd1,  5'd0,  1'b0, 32'hFFFFFFFF, 1'b0, '{1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0}},
      '{1'b0, 5'd1,  5'd0,  1'b0, 32'h00000001, 1'b1,
        '{1'b1, 2'd1, 32'hFFFFFFFF, 1'b1, 32'h0, 1'b0}},
      '{1'b0, 5'd1,  5'd0,  1'b0, 32'hDEADBEEF, 1'b0, NO_TYPED},
      '{1'b0, 5'd1,  5'd0,  1'b0, 32'h13579BDF, 1'b0, NO_TYPED},
      '{1'b0, 5'd1,  5'd0,  1'b0, 32'h2468ACE0, 1'b1, NO_TYPED},
      // new format passes words through
      '{1'b1, 5'd16, 5'd16, 1'b1, 32'hCAFEF00D, 1'b0,
        '{1'b1, 2'd1, 32'hCAFEF00D, 1'b0, 32'h0, 1'b0}},
      '{1'b0, 5'd16, 5'd16, 1'b1, 32'h0000FFFF, 1'b1,
        '{1'b1, 2'd1, 32'h0000FFFF, 1'b1, 32'h0, 1'b0}},
      // shift changed in the middle of a row
      '{1'b1, 5'd4,  5'd31, 1'b0, 32'h11111111, 1'b0, '{1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0}},
      '{1'b1, 5'd28, 5'd3,  1'b0, 32'h22222222, 1'b1, NO_TYPED},
      // new format switched on mid-row discards the held word
      '{1'b1, 5'd8,  5'd31, 1'b0, 32'h33333333, 1'b0, '{1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0}},
      '{1'b1, 5'd8,  5'd31, 1'b1, 32'h44444444, 1'b0,
        '{1'b1, 2'd1, 32'h44444444, 1'b0, 32'h0, 1'b0}},
      '{1'b1, 5'd8,  5'd31, 1'b0, 32'h55555555, 1'b1,
        '{1'b1, 2'd1, 32'h00555555, 1'b1, 32'h0, 1'b0}},
      // zero shift with edge zero
      '{1'b1, 5'd0,  5'd0,  1'b0, 32'h7FFFFFFF, 1'b0, NO_TYPED},
      '{1'b0, 5'd0,  5'd0,  1'b0, 32'hFFFFFFFE, 1'b1, NO_TYPED}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [WORD_W-1:0]   req_word_in;
   logic                req_row_end;
   typed_result_type    req_note;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [WORD_W-1:0]   rsp_word_out;
   logic                rsp_row_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic [SHIFT_W-1:0]  csr_wdata;

   int                  send_idle_pct;
   int                  recv_idle_pct;
   logic                rx_stall;
   event                rx_stall_start;

   // predictor state and register copy
   logic [SHIFT_W-1:0]  cfg_shift   = '0;
   logic [SHIFT_W-1:0]  cfg_redge   = 5'd31;
   logic                cfg_fmt     = 1'b0;
   logic [WORD_W-1:0]   held_word   = '0;
   bit                  held_valid  = 1'b0;

   dest_word_type       realigned_q [$];
   int                  error_count   = 0;
   int                  words_in      = 0;
   int                  words_checked = 0;
   int                  tails_dropped = 0;
   int                  cfg_settings  = 0;

   row_word_realigner DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word_in  (req_word_in),
      .req_row_end  (req_row_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word_out (rsp_word_out),
      .rsp_row_last (rsp_row_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard limit on the run
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // long receiver hold-off, started on request from the main sequence
   initial begin
      rx_stall <= 1'b0;
      forever begin
         @(rx_stall_start);
         @(posedge clock);
         rx_stall <= 1'b1;
         repeat (RX_STALL_CYCLES) @(posedge clock);
         rx_stall <= 1'b0;
      end
   end

   // receiver ready, idling at random
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= !rx_stall && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // queue one expected destination word
   function automatic void push_word(logic [WORD_W-1:0] w, logic last);
      dest_word_type d;
      d.word = w;
      d.last = last;
      realigned_q.push_back(d);
   endfunction

   // funnel-shift predictor for one source word
   function automatic void realign_word(logic [WORD_W-1:0] w, logic row_end);
      logic [SHIFT_W-1:0] s;
      bit                 drop;
      logic [WORD_W-1:0]  joined;
      s = cfg_shift;
      if (s == 0 || cfg_fmt) begin
         held_valid = 1'b0;
         push_word(w, row_end);
         return;
      end
      drop = cfg_redge < s;
      if (held_valid) begin
         joined = (held_word >> s) | (w << (WORD_W - s));
         push_word(joined, row_end && drop);
      end
      held_word  = w;
      held_valid = 1'b1;
      if (row_end) begin
         if (!drop) push_word(w >> s, 1'b1);
         else tails_dropped++;
         held_valid = 1'b0;
      end
   endfunction

   // monitor: check results first, then predict from accepted requests and writes
   always @(posedge clock) begin
      int            base;
      dest_word_type exp_word;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (realigned_q.size() == 0) begin
               $error("unexpected result: word_out %h row_last %b", rsp_word_out, rsp_row_last);
               error_count++;
            end else begin
               exp_word = realigned_q.pop_front();
               words_checked++;
               if (rsp_word_out !== exp_word.word) begin
                  $error("word_out expected %h actual %h", exp_word.word, rsp_word_out);
                  error_count++;
               end
               if (rsp_row_last !== exp_word.last) begin
                  $error("row_last expected %b actual %b", exp_word.last, rsp_row_last);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            words_in++;
            base = realigned_q.size();
            realign_word(req_word_in, req_row_end);
            // hand-typed results replace the predicted ones for this request
            if (req_note.on) begin
               while (realigned_q.size() > base) void'(realigned_q.pop_back());
               if (req_note.count >= 1) push_word(req_note.w0, req_note.l0);
               if (req_note.count >= 2) push_word(req_note.w1, req_note.l1);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEFT_SHIFT: cfg_shift = csr_wdata;
               CSR_RIGHT_EDGE: cfg_redge = csr_wdata;
               CSR_NEW_FORMAT: cfg_fmt   = csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // offer one request, idling at random first; returns at the accepting edge
   task automatic send_word(logic [WORD_W-1:0] w, logic row_end, typed_result_type note);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_word_in <= w;
      req_row_end <= row_end;
      req_note    <= note;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and wait until every expected word has come out
   task automatic wait_drained();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      @(posedge clock);
      while (realigned_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic wait_csr();
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // write all three registers, and optionally the unused index
   task automatic program_regs(logic [SHIFT_W-1:0] shift, logic [SHIFT_W-1:0] redge,
                               logic [SHIFT_W-1:0] fmt_word, bit with_spare);
      csr_valid <= 1'b1;
      csr_index <= CSR_LEFT_SHIFT;
      csr_wdata <= shift;
      wait_csr();
      csr_index <= CSR_RIGHT_EDGE;
      csr_wdata <= redge;
      wait_csr();
      csr_index <= CSR_NEW_FORMAT;
      csr_wdata <= fmt_word;
      wait_csr();
      if (with_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= SHIFT_W'($urandom_range(31));
         wait_csr();
      end
      csr_valid <= 1'b0;
      cfg_settings++;
   endtask

   // random register setting, weighted toward the extremes
   task automatic random_setting();
      logic [SHIFT_W-1:0] shift;
      logic [SHIFT_W-1:0] redge;
      logic [SHIFT_W-1:0] fmt_word;
      case ($urandom_range(9))
         0:       shift = 5'd0;
         1:       shift = 5'd1;
         2:       shift = 5'd31;
         default: shift = SHIFT_W'($urandom_range(1, 31));
      endcase
      case ($urandom_range(7))
         0:       redge = 5'd0;
         1:       redge = 5'd31;
         2:       redge = shift - 5'd1;
         3:       redge = shift;
         default: redge = SHIFT_W'($urandom_range(31));
      endcase
      fmt_word    = SHIFT_W'($urandom_range(31));
      fmt_word[0] = ($urandom_range(9) == 0);
      program_regs(shift, redge, fmt_word, $urandom_range(4) == 0);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h1 << $urandom_range(31);
         default: return $urandom();
      endcase
   endfunction

   // rows of random length; the last row may be cut off mid-row
   task automatic random_rows(int count);
      int left;
      int len;
      left = count;
      while (left > 0) begin
         if ($urandom_range(99) < 25) len = 1;
         else if ($urandom_range(99) < 85) len = $urandom_range(2, 5);
         else len = $urandom_range(6, 20);
         for (int k = 0; k < len && left > 0; k++) begin
            send_word(pick_word(), k == len - 1, NO_TYPED);
            left--;
         end
      end
   endtask

   initial begin
      int  budget;
      int  len;
      bit  stalled;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_word_in   <= '0;
      req_row_end   <= 1'b0;
      req_note      <= NO_TYPED;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_LEFT_SHIFT;
      csr_wdata     <= '0;
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      stalled = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      for (int i = 0; i < DIR_N; i++) begin
         if (DIR_TABLE[i].set_cfg) begin
            wait_drained();
            program_regs(DIR_TABLE[i].shift, DIR_TABLE[i].redge,
                         {4'b0, DIR_TABLE[i].fmt}, 1'b0);
         end
         send_word(DIR_TABLE[i].word, DIR_TABLE[i].row_end, DIR_TABLE[i].note);
      end
      wait_drained();

      // random rows under three idle patterns
      for (int m = 0; m < 3; m++) begin
         send_idle_pct <= SEND_IDLE[m];
         recv_idle_pct <= RECV_IDLE[m];
         budget = RANDOM_WORDS / 3;
         while (budget > 0) begin
            random_setting();
            if (m == 2 && !stalled) begin
               // receiver holds off while requests keep coming
               stalled = 1'b1;
               -> rx_stall_start;
               len = STALL_BURST;
            end else begin
               len = $urandom_range(20, 120);
            end
            if (len > budget) len = budget;
            random_rows(len);
            budget -= len;
            wait_drained();
         end
      end

      wait_drained();
      if (realigned_q.size() != 0) begin
         $error("%0d expected words never came out", realigned_q.size());
         error_count++;
      end
      $display("Sent %0d source words over %0d register settings, with random and no idling.",
               words_in, cfg_settings);
      $display("Checked %0d realigned words; %0d row tails were dropped.",
               words_checked, tails_dropped);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/rwr_pkg.sv
rtl/rwr_front.sv
rtl/rwr_queue.sv
rtl/rwr_back.sv
rtl/row_word_realigner.sv
tb/sv/tb_top.sv
